### src/rpe_pkg.sv
// ----------------------------------------------------------------------------
// rpe_pkg: shared types and constants of the relocation patch engine
// Word layouts, op and status codes, CRC helper.
// ----------------------------------------------------------------------------
package rpe_pkg;

  // image store size and address width (byte_index is 14 bits wide)
  localparam int unsigned IMAGE_DEPTH = 16384;
  localparam int          IMAGE_AW    = 14;

  typedef enum logic [2:0] {
    OP_WRITE  = 3'd0,
    OP_READ   = 3'd1,
    OP_START  = 3'd2,
    OP_TAIL   = 3'd3,
    OP_FINISH = 3'd4
  } op_t;

  localparam logic [3:0] ST_WORKING     = 4'd0;
  localparam logic [3:0] ST_OK          = 4'd1;
  localparam logic [3:0] ST_BAD_TARGET  = 4'd2;
  localparam logic [3:0] ST_BAD_GAP     = 4'd3;
  localparam logic [3:0] ST_OFFSET_OUT  = 4'd4;
  localparam logic [3:0] ST_POINTER_OUT = 4'd5;
  localparam logic [3:0] ST_COUNT       = 4'd6;
  localparam logic [3:0] ST_LENGTH      = 4'd7;
  localparam logic [3:0] ST_CRC         = 4'd8;

  localparam logic [2:0] CFG_LINK     = 3'd0;
  localparam logic [2:0] CFG_TARGET   = 3'd1;
  localparam logic [2:0] CFG_IMAGE    = 3'd2;
  localparam logic [2:0] CFG_MEMORY   = 3'd3;
  localparam logic [2:0] CFG_RELOC    = 3'd4;
  localparam logic [2:0] CFG_TAIL     = 3'd5;
  localparam logic [2:0] CFG_CRCSTART = 3'd6;
  localparam logic [2:0] CFG_CRCEXP   = 3'd7;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;

  typedef struct packed {
    logic [2:0]  op;
    logic [13:0] byte_index;
    logic [7:0]  data_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0] read_byte;
    logic [3:0] status;
    logic       done_res;
  } out_word_t;

  // back-end engine states
  typedef enum logic [3:0] {
    BE_IDLE,
    BE_RD0, BE_RD1, BE_RD2, BE_RD3, BE_RDW,
    BE_CHK, BE_WR0, BE_WR1, BE_WR2, BE_WR3,
    BE_RESP
  } be_state_t;

  // one-byte reflected CRC-32 step
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

### src/rpe_front.sv
// ----------------------------------------------------------------------------
// rpe_front: input register stage
// Takes input words and holds them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module rpe_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  rpe_pkg::in_word_t in_data,
  output logic              q_valid,
  input  logic              q_pop,
  output rpe_pkg::in_word_t q_data
);

  rpe_pkg::in_word_t buf_r [2];
  logic              rd_ptr_r, wr_ptr_r;
  logic [1:0]        cnt_r;
  logic              push;

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_data   = buf_r[rd_ptr_r];

  // store incoming word
  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r] <= in_data;
    end
  end

  // advance pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= 1'b0;
      wr_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (q_pop) rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd2 |-> !push || q_pop) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> cnt_r != 2'd0) else $error("queue underflow");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("queue count invalid");

endmodule

### src/rpe_back.sv
// ----------------------------------------------------------------------------
// rpe_back: pass engine
// Executes queued words against the image store and the pass state.
// ----------------------------------------------------------------------------
module rpe_back #(
  parameter logic [31:0] RAM_FIRST     = 32'd536870912,
  parameter logic [31:0] RAM_LAST      = 32'd536936448,
  parameter logic [31:0] MAX_FOOTPRINT = 32'd65536
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  output logic               q_pop,
  input  rpe_pkg::in_word_t  q_data,
  input  logic [31:0]        link_address,
  input  logic [31:0]        target_address,
  input  logic [14:0]        image_bytes,
  input  logic [31:0]        memory_bytes,
  input  logic [12:0]        reloc_total,
  input  logic [13:0]        tail_bytes,
  input  logic [31:0]        crc_start,
  input  logic [31:0]        crc_expected,
  output logic               out_valid,
  input  logic               out_stall,
  output rpe_pkg::out_word_t out_data
);

  localparam int AW = rpe_pkg::IMAGE_AW;

  logic [7:0] mem [rpe_pkg::IMAGE_DEPTH];

  rpe_pkg::be_state_t state_r, state_nxt;
  logic [14:0] end_pos_r;
  logic [12:0] relocs_r;
  logic [20:0] gap_r;
  logic [1:0]  shift_r;
  logic [13:0] consumed_r;
  logic [31:0] crc_r;
  logic [3:0]  status_r;
  logic        active_r;
  logic [31:0] ptr_r;
  logic [7:0]  rd_byte_r;
  logic [1:0]  bsel_r;
  logic        ovalid_r;
  rpe_pkg::out_word_t odata_r;

  // memory port controls
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [7:0]    mem_wd;
  logic          rd_en;

  // decode of the queued word
  rpe_pkg::op_t op;
  logic         idx_ok;
  logic         bad_target;
  logic [20:0]  gap_new;
  logic [31:0]  ptr_shift;

  assign op     = rpe_pkg::op_t'(q_data.op);
  assign idx_ok = ({18'd0, q_data.byte_index} < 32'(rpe_pkg::IMAGE_DEPTH));
  assign bad_target = (target_address < RAM_FIRST) || (memory_bytes > MAX_FOOTPRINT) ||
                      (memory_bytes > RAM_LAST) ||
                      ({1'b0, target_address} > ({1'b0, RAM_LAST} - {1'b0, memory_bytes})) ||
                      (target_address[2:0] != 3'd0) ||
                      ({17'd0, image_bytes} > 32'(rpe_pkg::IMAGE_DEPTH));
  assign gap_new = gap_r | ({14'd0, q_data.data_byte[6:0]} << (5'd7 * {3'd0, shift_r}));
  assign ptr_shift = ptr_r + (target_address - link_address);

  // offset checks for a completed gap (gap held in gap_r at BE_RD0)
  logic        off_bad;
  logic [21:0] room;
  assign room    = {7'd0, image_bytes} - {7'd0, end_pos_r};
  assign off_bad = (end_pos_r > image_bytes) || ({1'b0, gap_r} > room) ||
                   ((room - {1'b0, gap_r}) < 22'd4);

  logic [15:0] off_base;
  assign off_base = {1'b0, end_pos_r} + gap_r[15:0] + {14'd0, bsel_r};

  // whole pointer at BE_CHK: top byte still in the read register
  logic [31:0] ptr_full;
  assign ptr_full = {rd_byte_r, ptr_r[23:0]};

  // memory port
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wd;
    if (rd_en) rd_byte_r <= mem[mem_addr];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rpe_pkg::BE_IDLE: begin
        if (q_valid && !ovalid_r) begin
          if (op == rpe_pkg::OP_TAIL && active_r && status_r == rpe_pkg::ST_WORKING &&
              consumed_r < tail_bytes && relocs_r < reloc_total &&
              !(shift_r != 2'd0 && q_data.data_byte == 8'd0) && !q_data.data_byte[7])
            state_nxt = rpe_pkg::BE_RD0;
          else
            state_nxt = rpe_pkg::BE_RESP;
        end
      end
      rpe_pkg::BE_RD0: state_nxt = off_bad ? rpe_pkg::BE_RESP : rpe_pkg::BE_RD1;
      rpe_pkg::BE_RD1: state_nxt = rpe_pkg::BE_RD2;
      rpe_pkg::BE_RD2: state_nxt = rpe_pkg::BE_RD3;
      rpe_pkg::BE_RD3: state_nxt = rpe_pkg::BE_RDW;
      rpe_pkg::BE_RDW: state_nxt = rpe_pkg::BE_CHK;
      rpe_pkg::BE_CHK: state_nxt = ((ptr_full < link_address) ||
                                   ((ptr_full - link_address) > memory_bytes)) ?
                                   rpe_pkg::BE_RESP : rpe_pkg::BE_WR0;
      rpe_pkg::BE_WR0: state_nxt = rpe_pkg::BE_WR1;
      rpe_pkg::BE_WR1: state_nxt = rpe_pkg::BE_WR2;
      rpe_pkg::BE_WR2: state_nxt = rpe_pkg::BE_WR3;
      rpe_pkg::BE_WR3: state_nxt = rpe_pkg::BE_RESP;
      rpe_pkg::BE_RESP: state_nxt = rpe_pkg::BE_IDLE;
      default: state_nxt = rpe_pkg::BE_IDLE;
    endcase
  end

  // memory port drive
  always_comb begin
    mem_we   = 1'b0;
    rd_en    = 1'b0;
    mem_addr = q_data.byte_index[AW-1:0];
    mem_wd   = q_data.data_byte;
    case (state_r)
      rpe_pkg::BE_IDLE: begin
        if (q_valid && !ovalid_r && idx_ok) begin
          mem_we = (op == rpe_pkg::OP_WRITE);
          rd_en  = (op == rpe_pkg::OP_READ);
        end
      end
      rpe_pkg::BE_RD1, rpe_pkg::BE_RD2, rpe_pkg::BE_RD3, rpe_pkg::BE_RDW: begin
        rd_en    = 1'b1;
        mem_addr = off_base[AW-1:0];
      end
      rpe_pkg::BE_WR0, rpe_pkg::BE_WR1, rpe_pkg::BE_WR2, rpe_pkg::BE_WR3: begin
        mem_we   = 1'b1;
        mem_addr = off_base[AW-1:0];
        case (bsel_r)
          2'd0: mem_wd = ptr_shift[7:0];
          2'd1: mem_wd = ptr_shift[15:8];
          2'd2: mem_wd = ptr_shift[23:16];
          default: mem_wd = ptr_shift[31:24];
        endcase
      end
      default: ;
    endcase
  end

  assign q_pop = (state_r == rpe_pkg::BE_RESP);

  // state and pass registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= rpe_pkg::BE_IDLE;
      end_pos_r  <= '0;
      relocs_r   <= '0;
      gap_r      <= '0;
      shift_r    <= '0;
      consumed_r <= '0;
      crc_r      <= '0;
      status_r   <= rpe_pkg::ST_WORKING;
      active_r   <= 1'b0;
      bsel_r     <= '0;
      ovalid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (ovalid_r && !out_stall) ovalid_r <= 1'b0;
      case (state_r)
        rpe_pkg::BE_IDLE: begin
          bsel_r <= 2'd0;
          if (q_valid && !ovalid_r) begin
            case (op)
              rpe_pkg::OP_START: begin
                end_pos_r <= '0; relocs_r <= '0; gap_r <= '0; shift_r <= '0;
                consumed_r <= '0; crc_r <= crc_start; active_r <= 1'b1;
                if (bad_target) status_r <= rpe_pkg::ST_BAD_TARGET;
                else if ({2'd0, reloc_total} > {2'd0, image_bytes[14:2]})
                  status_r <= rpe_pkg::ST_COUNT;
                else status_r <= rpe_pkg::ST_WORKING;
              end
              rpe_pkg::OP_TAIL: begin
                if (active_r && status_r == rpe_pkg::ST_WORKING) begin
                  if (consumed_r >= tail_bytes || relocs_r >= reloc_total) begin
                    status_r <= rpe_pkg::ST_LENGTH;
                  end else begin
                    consumed_r <= consumed_r + 14'd1;
                    crc_r <= rpe_pkg::crc_byte(crc_r, q_data.data_byte);
                    if (shift_r != 2'd0 && q_data.data_byte == 8'd0)
                      status_r <= rpe_pkg::ST_BAD_GAP;
                    else if (q_data.data_byte[7]) begin
                      gap_r <= gap_new;
                      if (shift_r >= 2'd2) status_r <= rpe_pkg::ST_BAD_GAP;
                      else shift_r <= shift_r + 2'd1;
                    end else begin
                      gap_r   <= gap_new;
                      shift_r <= 2'd0;
                    end
                  end
                end
              end
              rpe_pkg::OP_FINISH: begin
                if (active_r && status_r == rpe_pkg::ST_WORKING) begin
                  if (relocs_r < reloc_total || consumed_r != tail_bytes)
                    status_r <= rpe_pkg::ST_LENGTH;
                  else if ((crc_r ^ 32'hFFFFFFFF) != crc_expected)
                    status_r <= rpe_pkg::ST_CRC;
                  else status_r <= rpe_pkg::ST_OK;
                end
              end
              default: ;
            endcase
          end
        end
        rpe_pkg::BE_RD0: begin
          if (off_bad) status_r <= rpe_pkg::ST_OFFSET_OUT;
          bsel_r <= 2'd0;
        end
        rpe_pkg::BE_RD1, rpe_pkg::BE_RD2, rpe_pkg::BE_RD3: bsel_r <= bsel_r + 2'd1;
        rpe_pkg::BE_RDW: bsel_r <= 2'd0;
        rpe_pkg::BE_CHK: begin
          if (state_nxt == rpe_pkg::BE_RESP) status_r <= rpe_pkg::ST_POINTER_OUT;
        end
        rpe_pkg::BE_WR0, rpe_pkg::BE_WR1, rpe_pkg::BE_WR2: bsel_r <= bsel_r + 2'd1;
        rpe_pkg::BE_WR3: begin
          end_pos_r <= off_base[14:0] + 15'd1;
          relocs_r  <= relocs_r + 13'd1;
        end
        rpe_pkg::BE_RESP: begin
          ovalid_r <= 1'b1;
          if (gap_r != 21'd0 && shift_r == 2'd0 && q_data.op == rpe_pkg::OP_TAIL)
            gap_r <= '0;
        end
        default: ;
      endcase
    end
  end

  // gather pointer bytes (each read byte is registered and taken in the state after its address)
  always_ff @(posedge clk) begin
    case (state_r)
      rpe_pkg::BE_RD2: ptr_r[7:0]   <= rd_byte_r;
      rpe_pkg::BE_RD3: ptr_r[15:8]  <= rd_byte_r;
      rpe_pkg::BE_RDW: ptr_r[23:16] <= rd_byte_r;
      rpe_pkg::BE_CHK: ptr_r[31:24] <= rd_byte_r;
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (state_r == rpe_pkg::BE_RESP) begin
      odata_r.read_byte <= (q_data.op == rpe_pkg::OP_READ && idx_ok) ? rd_byte_r : 8'd0;
      odata_r.status    <= status_r;
      odata_r.done_res  <= (status_r != rpe_pkg::ST_WORKING);
    end
  end

  assign out_valid = ovalid_r;
  assign out_data  = odata_r;

  a_resp_free: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == rpe_pkg::BE_RESP |-> !ovalid_r) else $error("resp");
  a_write_after_check: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == rpe_pkg::BE_WR0 |-> $past(state_r) == rpe_pkg::BE_CHK) else $error("wr order");
  a_pop_one: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> !q_pop) else $error("double pop");

endmodule

### src/relocation_patch_engine.sv
// A tail byte that completes a gap runs, one step after another on the single
// store port, through an offset check, four store reads, a pointer check and
// four store writes. The back end takes the next word only once the last result
// has been accepted, so a stalled result holds the back end. Reset: synchronous
// active-low rst_n clears the queue, the pass state and the configuration
// registers; the image store is not cleared.
// ----------------------------------------------------------------------------
// relocation_patch_engine: top level
// Configuration registers, input queue and pass engine.
// ----------------------------------------------------------------------------
module relocation_patch_engine #(
  parameter logic [31:0] RAM_FIRST     = 32'd536870912,
  parameter logic [31:0] RAM_LAST      = 32'd536936448,
  parameter logic [31:0] MAX_FOOTPRINT = 32'd65536
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  rpe_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output rpe_pkg::out_word_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  logic [31:0] link_r, target_r, memory_r, crcs_r, crce_r;
  logic [14:0] image_r;
  logic [12:0] reloc_r;
  logic [13:0] tail_r;
  logic        q_valid, q_pop;
  rpe_pkg::in_word_t q_data;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_r <= '0; target_r <= '0; image_r <= '0; memory_r <= '0;
      reloc_r <= '0; tail_r <= '0; crcs_r <= '0; crce_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        rpe_pkg::CFG_LINK:     link_r   <= cfg_data;
        rpe_pkg::CFG_TARGET:   target_r <= cfg_data;
        rpe_pkg::CFG_IMAGE:    image_r  <= cfg_data[14:0];
        rpe_pkg::CFG_MEMORY:   memory_r <= cfg_data;
        rpe_pkg::CFG_RELOC:    reloc_r  <= cfg_data[12:0];
        rpe_pkg::CFG_TAIL:     tail_r   <= cfg_data[13:0];
        rpe_pkg::CFG_CRCSTART: crcs_r   <= cfg_data;
        rpe_pkg::CFG_CRCEXP:   crce_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  rpe_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .q_valid(q_valid), .q_pop(q_pop), .q_data(q_data)
  );

  rpe_back #(
    .RAM_FIRST(RAM_FIRST), .RAM_LAST(RAM_LAST), .MAX_FOOTPRINT(MAX_FOOTPRINT)
  ) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_pop(q_pop), .q_data(q_data),
    .link_address(link_r), .target_address(target_r), .image_bytes(image_r),
    .memory_bytes(memory_r), .reloc_total(reloc_r), .tail_bytes(tail_r),
    .crc_start(crcs_r), .crc_expected(crce_r),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

endmodule

### sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: relocation patch engine testbench
// Drives image write, read, start, tail and finish words with random idling on both
// channels, predicts every result word and compares it field by field.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned DEPTH       = 16384;
  localparam logic [31:0] RAM_LO      = 32'd536870912;
  localparam logic [31:0] RAM_HI      = 32'd536936448;
  localparam logic [31:0] FOOT_MAX    = 32'd65536;
  localparam int          WATCHDOG    = 20000;
  localparam int          ITEM_TARGET = 1040;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  rpe_pkg::in_word_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  rpe_pkg::out_word_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  relocation_patch_engine dut (.*);

  always #5 clk = ~clk;

  // predictor state
  logic [31:0] r_link, r_target, r_mem, r_crc0, r_crcx;
  logic [14:0] r_img;
  logic [12:0] r_nrel;
  logic [13:0] r_ntail;
  logic [7:0]  img_mem [DEPTH];
  bit          img_known [DEPTH];
  logic [31:0] p_end, p_done, p_gap, p_shift, p_used, p_crc;
  logic [3:0]  p_status;
  bit          p_open;

  rpe_pkg::in_word_t  pending_words[$];
  rpe_pkg::out_word_t expected_words[$];
  int  send_idle_pct = 0, recv_idle_pct = 0;
  int  errors = 0;
  int  quiet_cycles = 0;
  int  n_accepted = 0;
  bit  hold_send = 1'b0;

  function automatic logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
    c = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ 32'hEDB88320) : (c >> 1);
    return c;
  endfunction

  task automatic patch_word(logic [31:0] gap);
    logic [31:0] off, ptr;
    if (p_end > r_img || gap > r_img - p_end || r_img - p_end - gap < 4) begin
      p_status = rpe_pkg::ST_OFFSET_OUT;
      return;
    end
    off = p_end + gap;
    ptr = {img_mem[off+3], img_mem[off+2], img_mem[off+1], img_mem[off]};
    if (ptr < r_link || ptr - r_link > r_mem) begin
      p_status = rpe_pkg::ST_POINTER_OUT;
      return;
    end
    ptr = ptr + (r_target - r_link);
    {img_mem[off+3], img_mem[off+2], img_mem[off+1], img_mem[off]} = ptr;
    p_end = off + 4;
    p_done++;
  endtask

  // compute the result word for one accepted input word
  task automatic predict_patch(rpe_pkg::in_word_t w);
    rpe_pkg::out_word_t r;
    logic [7:0] b;
    r = '0;
    b = w.data_byte;
    case (w.op)
      rpe_pkg::OP_WRITE: begin
        img_mem[w.byte_index] = b;
        img_known[w.byte_index] = 1'b1;
      end
      rpe_pkg::OP_READ: r.read_byte = img_mem[w.byte_index];
      rpe_pkg::OP_START: begin
        p_end = 0; p_done = 0; p_gap = 0; p_shift = 0; p_used = 0;
        p_crc = r_crc0; p_status = rpe_pkg::ST_WORKING; p_open = 1'b1;
        if (r_target < RAM_LO || r_mem > FOOT_MAX || r_mem > RAM_HI ||
            {32'd0, r_target} > {32'd0, RAM_HI} - {32'd0, r_mem} ||
            r_target[2:0] != 3'd0 || r_img > DEPTH)
          p_status = rpe_pkg::ST_BAD_TARGET;
        else if (r_nrel > r_img / 4)
          p_status = rpe_pkg::ST_COUNT;
      end
      rpe_pkg::OP_TAIL: begin
        if (p_open && p_status == rpe_pkg::ST_WORKING) begin
          if (p_used >= r_ntail || p_done >= r_nrel) p_status = rpe_pkg::ST_LENGTH;
          else begin
            p_used++;
            p_crc = crc_step(p_crc, b);
            if (p_shift != 0 && b == 0) p_status = rpe_pkg::ST_BAD_GAP;
            else begin
              p_gap = p_gap | ({25'd0, b[6:0]} << (7 * p_shift));
              if (b[7]) begin
                if (p_shift >= 2) p_status = rpe_pkg::ST_BAD_GAP;
                else p_shift++;
              end else begin
                logic [31:0] g;
                g = p_gap & 32'h1FFFFF;
                p_gap = 0;
                p_shift = 0;
                patch_word(g);
              end
            end
          end
        end
      end
      rpe_pkg::OP_FINISH: begin
        if (p_open && p_status == rpe_pkg::ST_WORKING) begin
          if (p_done < r_nrel || p_used != r_ntail) p_status = rpe_pkg::ST_LENGTH;
          else if ((p_crc ^ 32'hFFFFFFFF) != r_crcx) p_status = rpe_pkg::ST_CRC;
          else p_status = rpe_pkg::ST_OK;
        end
      end
      default: ;
    endcase
    r.status = p_status;
    r.done_res = (p_status != rpe_pkg::ST_WORKING);
    expected_words.push_back(r);
  endtask

  // driver: hold the word until accepted, then advance
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predict_patch(in_data);
        void'(pending_words.pop_front());
        n_accepted++;
      end
      if ((!in_valid || !in_stall)) begin
        if (pending_words.size() > 0 && !hold_send &&
            $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data <= pending_words[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // monitor: compare each result word with the oldest expectation
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles > WATCHDOG) begin
        $display("Mismatches found");
        $finish;
      end
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual %h", $time, out_data);
          errors++;
        end else begin
          rpe_pkg::out_word_t e;
          e = expected_words.pop_front();
          if (e.read_byte !== out_data.read_byte)
            $display("%0t: read_byte expected %h actual %h", $time, e.read_byte,
                     out_data.read_byte);
          if (e.status !== out_data.status)
            $display("%0t: status expected %0d actual %0d", $time, e.status,
                     out_data.status);
          if (e.done_res !== out_data.done_res)
            $display("%0t: done_res expected %b actual %b", $time, e.done_res,
                     out_data.done_res);
          if (e !== out_data) errors++;
        end
      end
    end
  end

  // wait until the block has drained every queued word
  task automatic drain();
    while (pending_words.size() > 0 || in_valid || expected_words.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      rpe_pkg::CFG_LINK:     r_link = val;
      rpe_pkg::CFG_TARGET:   r_target = val;
      rpe_pkg::CFG_IMAGE:    r_img = val[14:0];
      rpe_pkg::CFG_MEMORY:   r_mem = val;
      rpe_pkg::CFG_RELOC:    r_nrel = val[12:0];
      rpe_pkg::CFG_TAIL:     r_ntail = val[13:0];
      rpe_pkg::CFG_CRCSTART: r_crc0 = val;
      default:               r_crcx = val;
    endcase
  endtask

  function automatic rpe_pkg::in_word_t mk(rpe_pkg::op_t op, int idx, int b);
    rpe_pkg::in_word_t w;
    w.op = op;
    w.byte_index = idx[13:0];
    w.data_byte = b[7:0];
    return w;
  endfunction

  // a pass: image with pointers and matching tail, at times a corrupted tail, a wrong CRC or an extra tail byte
  task automatic build_pass(int nbytes, bit corrupt);
    int nrel, pos, n;
    logic [31:0] link, tgt, crc, mem;
    byte unsigned tail[$];
    nbytes = nbytes & ~3;
    if (nbytes < 8) nbytes = 8;
    link = $urandom;
    tgt = RAM_LO + ($urandom_range(1000) * 8);
    mem = $urandom_range(nbytes + 64, 4096);
    for (int i = 0; i < nbytes; i++) begin
      pending_words.push_back(mk(rpe_pkg::OP_WRITE, i, $urandom));
      img_known[i] = 1'b1;
    end
    pos = 0;
    nrel = 0;
    while (pos + 4 <= nbytes && nrel < 6) begin
      int gap;
      logic [31:0] ptr;
      gap = $urandom_range(0, (nbytes - pos - 4 > 20) ? 20 : nbytes - pos - 4);
      if ($urandom_range(9) == 0 && nbytes - pos - 4 >= 200) gap = 130 + $urandom_range(60);
      ptr = link + $urandom_range(0, mem);
      for (int k = 0; k < 4; k++)
        pending_words.push_back(mk(rpe_pkg::OP_WRITE, pos + gap + k, ptr >> (8 * k)));
      if (gap >= 128) begin
        tail.push_back(8'h80 | {1'b0, gap[6:0]});
        tail.push_back(8'(gap >> 7));
      end else tail.push_back(8'(gap));
      pos = pos + gap + 4;
      nrel++;
    end
    if (corrupt && tail.size() > 0) tail[$urandom_range(tail.size() - 1)] ^= 8'h81;
    crc = $urandom;
    n = tail.size();
    drain();
    write_reg(rpe_pkg::CFG_LINK, link);
    write_reg(rpe_pkg::CFG_TARGET, tgt);
    write_reg(rpe_pkg::CFG_IMAGE, nbytes);
    write_reg(rpe_pkg::CFG_MEMORY, mem);
    write_reg(rpe_pkg::CFG_RELOC, nrel);
    write_reg(rpe_pkg::CFG_TAIL, n);
    write_reg(rpe_pkg::CFG_CRCSTART, crc);
    for (int i = 0; i < n; i++) crc = crc_step(crc, tail[i]);
    write_reg(rpe_pkg::CFG_CRCEXP, ($urandom_range(7) == 0) ? ~crc ^ 1 : ~crc);
    pending_words.push_back(mk(rpe_pkg::OP_START, 0, 0));
    for (int i = 0; i < n; i++) pending_words.push_back(mk(rpe_pkg::OP_TAIL, 0, tail[i]));
    if ($urandom_range(9) == 0)
      pending_words.push_back(mk(rpe_pkg::OP_TAIL, 0, $urandom));
    pending_words.push_back(mk(rpe_pkg::OP_FINISH, 0, 0));
    for (int i = 0; i < 4; i++)
      pending_words.push_back(mk(rpe_pkg::OP_READ, $urandom_range(nbytes - 1), 0));
  endtask

  initial begin
    int passes;
    r_link = 0; r_target = 0; r_img = 0; r_mem = 0; r_nrel = 0; r_ntail = 0;
    r_crc0 = 0; r_crcx = 0; p_end = 0; p_done = 0; p_gap = 0; p_shift = 0;
    p_used = 0; p_crc = 0; p_status = rpe_pkg::ST_WORKING; p_open = 1'b0;
    for (int i = 0; i < DEPTH; i++) begin
      img_mem[i] = 8'h00;
      img_known[i] = 1'b0;
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: tail and finish before any start, store extremes
    pending_words.push_back(mk(rpe_pkg::OP_TAIL, 0, 8'hFF));
    pending_words.push_back(mk(rpe_pkg::OP_FINISH, 0, 0));
    pending_words.push_back(mk(rpe_pkg::OP_WRITE, 0, 8'hFF));
    pending_words.push_back(mk(rpe_pkg::OP_WRITE, DEPTH - 1, 8'h00));
    pending_words.push_back(mk(rpe_pkg::OP_READ, 0, 0));
    pending_words.push_back(mk(rpe_pkg::OP_READ, DEPTH - 1, 8'hFF));
    pending_words.push_back(mk(rpe_pkg::op_t'(3'd5), 16383, 8'hAA));
    pending_words.push_back(mk(rpe_pkg::op_t'(3'd7), 0, 8'h55));
    img_known[0] = 1; img_known[DEPTH-1] = 1;
    // bad target with all-zero registers
    pending_words.push_back(mk(rpe_pkg::OP_START, 0, 0));
    pending_words.push_back(mk(rpe_pkg::OP_TAIL, 0, 1));
    drain();
    // bad target at register extremes
    write_reg(rpe_pkg::CFG_TARGET, 32'hFFFFFFFF);
    write_reg(rpe_pkg::CFG_MEMORY, 32'hFFFFFFFF);
    write_reg(rpe_pkg::CFG_IMAGE, 16384);
    write_reg(rpe_pkg::CFG_RELOC, 4096);
    write_reg(rpe_pkg::CFG_TAIL, 12288);
    write_reg(rpe_pkg::CFG_LINK, 32'hFFFFFFFF);
    write_reg(rpe_pkg::CFG_CRCSTART, 32'hFFFFFFFF);
    write_reg(rpe_pkg::CFG_CRCEXP, 32'hFFFFFFFF);
    pending_words.push_back(mk(rpe_pkg::OP_START, 0, 0));
    drain();
    // count too large, then long gap, padded gap, offset out of range, early finish
    write_reg(rpe_pkg::CFG_TARGET, RAM_LO);
    write_reg(rpe_pkg::CFG_MEMORY, 64);
    write_reg(rpe_pkg::CFG_IMAGE, 16);
    write_reg(rpe_pkg::CFG_RELOC, 5);
    pending_words.push_back(mk(rpe_pkg::OP_START, 0, 0));
    drain();
    write_reg(rpe_pkg::CFG_RELOC, 2);
    write_reg(rpe_pkg::CFG_TAIL, 8);
    pending_words.push_back(mk(rpe_pkg::OP_START, 0, 0));
    pending_words.push_back(mk(rpe_pkg::OP_TAIL, 0, 8'h80));
    pending_words.push_back(mk(rpe_pkg::OP_TAIL, 0, 8'h81));
    pending_words.push_back(mk(rpe_pkg::OP_TAIL, 0, 8'h82));
    pending_words.push_back(mk(rpe_pkg::OP_START, 0, 0));
    pending_words.push_back(mk(rpe_pkg::OP_TAIL, 0, 8'h85));
    pending_words.push_back(mk(rpe_pkg::OP_TAIL, 0, 8'h00));
    pending_words.push_back(mk(rpe_pkg::OP_START, 0, 0));
    pending_words.push_back(mk(rpe_pkg::OP_TAIL, 0, 8'h7F));
    pending_words.push_back(mk(rpe_pkg::OP_START, 0, 0));
    pending_words.push_back(mk(rpe_pkg::OP_FINISH, 0, 0));
    drain();

    // random: mostly well-formed passes, some broken, plus noise
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 31 : (phase == 1) ? 59 : 0;
      recv_idle_pct = (phase == 0) ? 59 : (phase == 1) ? 31 : 0;
      passes = 0;
      while (n_accepted + pending_words.size() < ITEM_TARGET * (phase + 1) / 3) begin
        build_pass($urandom_range(3) == 0 ? $urandom_range(200, 400) : $urandom_range(8, 48),
                   $urandom_range(4) == 0);
        for (int j = 0; j < 6; j++) begin
          int i;
          i = $urandom_range(DEPTH - 1);
          if ($urandom_range(1)) begin
            pending_words.push_back(mk(rpe_pkg::OP_WRITE, i, $urandom));
            img_known[i] = 1;
          end else if (img_known[i])
            pending_words.push_back(mk(rpe_pkg::OP_READ, i, 0));
          else
            pending_words.push_back(mk(rpe_pkg::op_t'($urandom_range(2, 4)), i, $urandom));
        end
        passes++;
        if (passes == 1) begin
          // hold off sending until every result has come
          hold_send = 1'b1;
          while (expected_words.size() > 0 || in_valid) @(posedge clk);
          hold_send = 1'b0;
        end
      end
    end
    drain();
    if (errors == 0 && expected_words.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
